>>> sv/iwsa_pkg.sv
// shared types and constants of the inverse warp source address unit
package iwsa_pkg;

    localparam int COORD_BITS_DEF     = 12;
    localparam int COEF_FRAC_BITS_DEF = 20;
    localparam int FIELD_BITS         = 12;
    localparam int COEF_BITS          = 32;
    localparam int SIZE_BITS          = 13;
    localparam int NUM_COEF           = 9;
    localparam int ADDR_BITS          = 6;
    localparam int DATA_BITS          = 64;

    localparam logic [2:0] REG_ROW0_A_B    = 3'd0;
    localparam logic [2:0] REG_ROW0C_ROW1A = 3'd1;
    localparam logic [2:0] REG_ROW1_B_C    = 3'd2;
    localparam logic [2:0] REG_ROW2_A_B    = 3'd3;
    localparam logic [2:0] REG_ROW2_C      = 3'd4;
    localparam logic [2:0] REG_PERSP       = 3'd5;
    localparam logic [2:0] REG_SRC_WIDTH   = 3'd6;
    localparam logic [2:0] REG_SRC_HEIGHT  = 3'd7;

    typedef struct packed {
        logic [FIELD_BITS-1:0] out_x;
        logic [FIELD_BITS-1:0] out_y;
    } t_in;

    typedef struct packed {
        logic [FIELD_BITS-1:0] src_x;
        logic [FIELD_BITS-1:0] src_y;
        logic                  inside_res;
    } t_out;

    // m[0..8] = m00 m01 m02 m10 m11 m12 m20 m21 m22
    typedef struct packed {
        logic [NUM_COEF-1:0][COEF_BITS-1:0] m;
        logic                               persp;
        logic [SIZE_BITS-1:0]               width;
        logic [SIZE_BITS-1:0]               height;
    } t_cfg;

    typedef struct packed {
        logic persp;
        logic bad;
        logic ovf_x;
        logic ovf_y;
        logic neg_x;
        logic neg_y;
    } t_side;

endpackage

>>> sv/iwsa_regs.sv
// apb configuration registers
module iwsa_regs #(
    parameter int COEF_FRAC_BITS = iwsa_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iwsa_pkg::ADDR_BITS-1:0] paddr,
    input  logic [iwsa_pkg::DATA_BITS-1:0] pwdata,
    output logic [iwsa_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output iwsa_pkg::t_cfg                 o_cfg
);
    localparam logic [31:0] ONE = 32'(64'd1 << COEF_FRAC_BITS);

    logic [2:0]    idx;
    logic          wr;
    iwsa_pkg::t_cfg r_cfg;

    assign idx    = paddr[5:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.m      <= {ONE, 32'd0, 32'd0, 32'd0, ONE, 32'd0, 32'd0, 32'd0, ONE};
            r_cfg.persp  <= 1'b1;
            r_cfg.width  <= 13'd4096;
            r_cfg.height <= 13'd4096;
        end else if (wr) begin
            case (idx)
                iwsa_pkg::REG_ROW0_A_B: begin
                    r_cfg.m[0] <= pwdata[31:0];
                    r_cfg.m[1] <= pwdata[63:32];
                end
                iwsa_pkg::REG_ROW0C_ROW1A: begin
                    r_cfg.m[2] <= pwdata[31:0];
                    r_cfg.m[3] <= pwdata[63:32];
                end
                iwsa_pkg::REG_ROW1_B_C: begin
                    r_cfg.m[4] <= pwdata[31:0];
                    r_cfg.m[5] <= pwdata[63:32];
                end
                iwsa_pkg::REG_ROW2_A_B: begin
                    r_cfg.m[6] <= pwdata[31:0];
                    r_cfg.m[7] <= pwdata[63:32];
                end
                iwsa_pkg::REG_ROW2_C:      r_cfg.m[8]   <= pwdata[31:0];
                iwsa_pkg::REG_PERSP:       r_cfg.persp  <= pwdata[0];
                iwsa_pkg::REG_SRC_WIDTH:   r_cfg.width  <= pwdata[12:0];
                iwsa_pkg::REG_SRC_HEIGHT:  r_cfg.height <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            iwsa_pkg::REG_ROW0_A_B:    prdata = {r_cfg.m[1], r_cfg.m[0]};
            iwsa_pkg::REG_ROW0C_ROW1A: prdata = {r_cfg.m[3], r_cfg.m[2]};
            iwsa_pkg::REG_ROW1_B_C:    prdata = {r_cfg.m[5], r_cfg.m[4]};
            iwsa_pkg::REG_ROW2_A_B:    prdata = {r_cfg.m[7], r_cfg.m[6]};
            iwsa_pkg::REG_ROW2_C:      prdata = {32'd0, r_cfg.m[8]};
            iwsa_pkg::REG_PERSP:       prdata = {63'd0, r_cfg.persp};
            iwsa_pkg::REG_SRC_WIDTH:   prdata = {51'd0, r_cfg.width};
            iwsa_pkg::REG_SRC_HEIGHT:  prdata = {51'd0, r_cfg.height};
            default:                   prdata = '0;
        endcase
    end

endmodule

>>> sv/iwsa_xform.sv
// matrix times (x, y, 1): product stage then sum stage
module iwsa_xform #(
    parameter int COORD_BITS = iwsa_pkg::COORD_BITS_DEF,
    parameter int SW         = 32 + COORD_BITS + 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  iwsa_pkg::t_cfg        i_cfg,
    output logic                  o_vld,
    output logic signed [SW-1:0]  o_u,
    output logic signed [SW-1:0]  o_v,
    output logic signed [SW-1:0]  o_w
);
    localparam int PW = 32 + COORD_BITS + 1;

    logic signed [PW-1:0] r_p [6];
    logic signed [31:0]   r_c [3];
    logic                 r_vld_a;
    logic                 r_vld_b;
    logic signed [SW-1:0] r_u, r_v, r_w;
    logic signed [COORD_BITS:0] sx, sy;

    assign sx = $signed({1'b0, i_x});
    assign sy = $signed({1'b0, i_y});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p[0] <= PW'($signed(i_cfg.m[0]) * sx);
            r_p[1] <= PW'($signed(i_cfg.m[1]) * sy);
            r_p[2] <= PW'($signed(i_cfg.m[3]) * sx);
            r_p[3] <= PW'($signed(i_cfg.m[4]) * sy);
            r_p[4] <= PW'($signed(i_cfg.m[6]) * sx);
            r_p[5] <= PW'($signed(i_cfg.m[7]) * sy);
            r_c[0] <= $signed(i_cfg.m[2]);
            r_c[1] <= $signed(i_cfg.m[5]);
            r_c[2] <= $signed(i_cfg.m[8]);
            r_u <= SW'(r_p[0]) + SW'(r_p[1]) + SW'(r_c[0]);
            r_v <= SW'(r_p[2]) + SW'(r_p[3]) + SW'(r_c[1]);
            r_w <= SW'(r_p[4]) + SW'(r_p[5]) + SW'(r_c[2]);
        end
    end

    assign o_vld = r_vld_b;
    assign o_u   = r_u;
    assign o_v   = r_v;
    assign o_w   = r_w;

endmodule

>>> sv/iwsa_div_step.sv
// one restoring division step for both coordinates
module iwsa_div_step #(
    parameter int NW  = 50,
    parameter int QB  = 13,
    parameter int BIT = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  iwsa_pkg::t_side   i_side,
    input  logic [NW-1:0]     i_den,
    input  logic [NW-1:0]     i_rem_x,
    input  logic [NW-1:0]     i_rem_y,
    input  logic [QB-1:0]     i_q_x,
    input  logic [QB-1:0]     i_q_y,
    output logic              o_vld,
    output iwsa_pkg::t_side   o_side,
    output logic [NW-1:0]     o_den,
    output logic [NW-1:0]     o_rem_x,
    output logic [NW-1:0]     o_rem_y,
    output logic [QB-1:0]     o_q_x,
    output logic [QB-1:0]     o_q_y
);
    localparam int TW = NW + QB + 1;

    logic [TW-1:0]   dsh, tx, ty;
    logic            gx, gy;
    logic [QB-1:0]   n_q_x, n_q_y;
    logic            r_vld;
    iwsa_pkg::t_side r_side;
    logic [NW-1:0]   r_den, r_rem_x, r_rem_y;
    logic [QB-1:0]   r_q_x, r_q_y;

    assign dsh   = TW'(i_den) << BIT;
    assign tx    = TW'(i_rem_x) - dsh;
    assign ty    = TW'(i_rem_y) - dsh;
    assign gx    = i_side.persp && !tx[TW-1];
    assign gy    = i_side.persp && !ty[TW-1];
    assign n_q_x = gx ? (i_q_x | (QB'(1) << BIT)) : i_q_x;
    assign n_q_y = gy ? (i_q_y | (QB'(1) << BIT)) : i_q_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side  <= i_side;
            r_den   <= i_den;
            r_rem_x <= gx ? tx[NW-1:0] : i_rem_x;
            r_rem_y <= gy ? ty[NW-1:0] : i_rem_y;
            r_q_x   <= n_q_x;
            r_q_y   <= n_q_y;
        end
    end

    assign o_vld   = r_vld;
    assign o_side  = r_side;
    assign o_den   = r_den;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_q_x   = r_q_x;
    assign o_q_y   = r_q_y;

endmodule

>>> sv/inverse_warp_source_address_unit.sv
// Inverse warp source address unit: maps each output pixel (out_x, out_y) through a
// configured 3x3 matrix in signed Q12.20 to a rounded source pixel with an inside flag.
// One transfer is taken per clock unless the output stalls. The pipeline runs through a
// product register, a sum register, a setup register, COORD_BITS + 1 restoring
// divider stages (one quotient bit per stage) and one output register. The whole pipeline
// stalls only while a result waits at the output and the downstream side is not ready.
module inverse_warp_source_address_unit #(
    parameter int COORD_BITS     = iwsa_pkg::COORD_BITS_DEF,
    parameter int COEF_FRAC_BITS = iwsa_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  iwsa_pkg::t_in                  i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output iwsa_pkg::t_out                 o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iwsa_pkg::ADDR_BITS-1:0] paddr,
    input  logic [iwsa_pkg::DATA_BITS-1:0] pwdata,
    output logic [iwsa_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);
    localparam int SW = 32 + COORD_BITS + 3;
    localparam int NW = SW + 2;
    localparam int QB = COORD_BITS + 1;
    localparam int LW = (QB > iwsa_pkg::SIZE_BITS) ? QB : iwsa_pkg::SIZE_BITS;

    iwsa_pkg::t_cfg cfg;
    logic           en;

    iwsa_regs #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg)
    );

    logic                 xf_vld;
    logic signed [SW-1:0] u, v, w;

    iwsa_xform #(.COORD_BITS(COORD_BITS), .SW(SW)) u_xform (
        .i_clk, .i_rst_n, .i_en(en), .i_vld(i_in_valid),
        .i_x(COORD_BITS'(i_in.out_x)), .i_y(COORD_BITS'(i_in.out_y)),
        .i_cfg(cfg), .o_vld(xf_vld), .o_u(u), .o_v(v), .o_w(w)
    );

    // setup stage: magnitudes, dividend, divisor, affine rounding
    logic [SW-1:0]      au, av, aw;
    logic [NW-1:0]      nx, ny, den;
    logic [NW+QB-1:0]   dtop;
    logic [SW:0]        qax, qay;
    iwsa_pkg::t_side    side0;
    logic [QB-1:0]      q0x, q0y;

    assign au   = u[SW-1] ? SW'(-u) : SW'(u);
    assign av   = v[SW-1] ? SW'(-v) : SW'(v);
    assign aw   = w[SW-1] ? SW'(-w) : SW'(w);
    assign nx   = (NW'(au) << 1) + NW'(aw);
    assign ny   = (NW'(av) << 1) + NW'(aw);
    assign den  = NW'(aw) << 1;
    assign dtop = (NW+QB)'(den) << QB;
    assign qax  = ((SW+1)'(au) + ((SW+1)'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
    assign qay  = ((SW+1)'(av) + ((SW+1)'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;

    always_comb begin
        side0.persp = cfg.persp;
        side0.bad   = cfg.persp && (w == '0);
        if (cfg.persp) begin
            side0.ovf_x = (NW+QB)'(nx) >= dtop;
            side0.ovf_y = (NW+QB)'(ny) >= dtop;
            side0.neg_x = u[SW-1] ^ w[SW-1];
            side0.neg_y = v[SW-1] ^ w[SW-1];
            q0x         = '0;
            q0y         = '0;
        end else begin
            side0.ovf_x = (qax >> QB) != '0;
            side0.ovf_y = (qay >> QB) != '0;
            side0.neg_x = u[SW-1];
            side0.neg_y = v[SW-1];
            q0x         = qax[QB-1:0];
            q0y         = qay[QB-1:0];
        end
    end

    logic            st_vld   [QB+1];
    iwsa_pkg::t_side st_side  [QB+1];
    logic [NW-1:0]   st_den   [QB+1];
    logic [NW-1:0]   st_rem_x [QB+1];
    logic [NW-1:0]   st_rem_y [QB+1];
    logic [QB-1:0]   st_q_x   [QB+1];
    logic [QB-1:0]   st_q_y   [QB+1];

    logic            r_s_vld;
    iwsa_pkg::t_side r_s_side;
    logic [NW-1:0]   r_s_den, r_s_nx, r_s_ny;
    logic [QB-1:0]   r_s_qx, r_s_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld <= 1'b0;
        end else if (en) begin
            r_s_vld <= xf_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_side <= side0;
            r_s_den  <= den;
            r_s_nx   <= nx;
            r_s_ny   <= ny;
            r_s_qx   <= q0x;
            r_s_qy   <= q0y;
        end
    end

    assign st_vld[0]   = r_s_vld;
    assign st_side[0]  = r_s_side;
    assign st_den[0]   = r_s_den;
    assign st_rem_x[0] = r_s_nx;
    assign st_rem_y[0] = r_s_ny;
    assign st_q_x[0]   = r_s_qx;
    assign st_q_y[0]   = r_s_qy;

    for (genvar s = 0; s < QB; s++) begin : g_div
        iwsa_div_step #(.NW(NW), .QB(QB), .BIT(QB - 1 - s)) u_step (
            .i_clk, .i_rst_n, .i_en(en), .i_vld(st_vld[s]), .i_side(st_side[s]),
            .i_den(st_den[s]), .i_rem_x(st_rem_x[s]), .i_rem_y(st_rem_y[s]),
            .i_q_x(st_q_x[s]), .i_q_y(st_q_y[s]),
            .o_vld(st_vld[s+1]), .o_side(st_side[s+1]), .o_den(st_den[s+1]),
            .o_rem_x(st_rem_x[s+1]), .o_rem_y(st_rem_y[s+1]),
            .o_q_x(st_q_x[s+1]), .o_q_y(st_q_y[s+1])
        );
    end

    // bounds check and output register
    iwsa_pkg::t_side fs;
    logic [QB-1:0]   fqx, fqy;
    logic            okx, oky, ok;
    logic            r_out_vld;
    iwsa_pkg::t_out  r_out;

    assign fs  = st_side[QB];
    assign fqx = st_q_x[QB];
    assign fqy = st_q_y[QB];
    assign okx = !fs.ovf_x && (!fs.neg_x || fqx == '0) && !fqx[QB-1]
                 && (LW'(fqx) < LW'(cfg.width));
    assign oky = !fs.ovf_y && (!fs.neg_y || fqy == '0) && !fqy[QB-1]
                 && (LW'(fqy) < LW'(cfg.height));
    assign ok  = !fs.bad && okx && oky;

    assign en = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= st_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.src_x      <= ok ? iwsa_pkg::FIELD_BITS'(fqx) : '0;
            r_out.src_y      <= ok ? iwsa_pkg::FIELD_BITS'(fqy) : '0;
            r_out.inside_res <= ok;
        end
    end

    assign o_in_ready  = en;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_zero_when_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.inside_res |-> o_out.src_x == '0 && o_out.src_y == '0)
        else $error("outside result with nonzero coordinates");
    a_inside_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.inside_res |->
            LW'(o_out.src_x) < LW'(cfg.width) && LW'(o_out.src_y) < LW'(cfg.height))
        else $error("inside result beyond source size");
    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_s_vld) && $stable(st_vld[QB]))
        else $error("pipeline moved during stall");
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");
`endif

endmodule

>>> tb/source_address_checker.sv
// checker: predicts source addresses from observed transfers and compares the results
module source_address_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  iwsa_pkg::t_in                  i_in,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  iwsa_pkg::t_out                 i_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iwsa_pkg::ADDR_BITS-1:0] paddr,
    input  logic [iwsa_pkg::DATA_BITS-1:0] pwdata,
    input  logic                           pready,
    output int                             o_pending,
    output int                             o_failures
);
    localparam int FRAC = iwsa_pkg::COEF_FRAC_BITS_DEF;
    localparam longint COORD_LIM = longint'(1) << iwsa_pkg::COORD_BITS_DEF;

    logic [63:0]                    row0_a_b;
    logic [63:0]                    row0c_row1a;
    logic [63:0]                    row1_b_c;
    logic [63:0]                    row2_a_b;
    logic [31:0]                    row2_c;
    logic                           persp;
    logic [iwsa_pkg::SIZE_BITS-1:0] width;
    logic [iwsa_pkg::SIZE_BITS-1:0] height;

    iwsa_pkg::t_out src_q[$];

    function automatic longint coef(logic [31:0] c);
        return longint'($signed(c));
    endfunction

    function automatic longint div_half_away(longint n, longint d);
        longint an;
        longint ad;
        longint q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic longint shift_half_away(longint n);
        longint an;
        longint q;
        an = (n < 0) ? -n : n;
        q = (an + (longint'(1) << (FRAC - 1))) >>> FRAC;
        return (n < 0) ? -q : q;
    endfunction

    function automatic iwsa_pkg::t_out predict_source(iwsa_pkg::t_in it);
        longint x;
        longint y;
        longint u;
        longint v;
        longint w;
        longint sx;
        longint sy;
        longint wl;
        longint hl;
        bit     ok;
        iwsa_pkg::t_out r;
        x = longint'(it.out_x);
        y = longint'(it.out_y);
        u = coef(row0_a_b[31:0]) * x + coef(row0_a_b[63:32]) * y + coef(row0c_row1a[31:0]);
        v = coef(row0c_row1a[63:32]) * x + coef(row1_b_c[31:0]) * y + coef(row1_b_c[63:32]);
        w = coef(row2_a_b[31:0]) * x + coef(row2_a_b[63:32]) * y + coef(row2_c);
        wl = (longint'(width) > COORD_LIM) ? COORD_LIM : longint'(width);
        hl = (longint'(height) > COORD_LIM) ? COORD_LIM : longint'(height);
        ok = 1'b1;
        sx = 0;
        sy = 0;
        if (persp) begin
            if (w == 0) begin
                ok = 1'b0;
            end else begin
                sx = div_half_away(u, w);
                sy = div_half_away(v, w);
            end
        end else begin
            sx = shift_half_away(u);
            sy = shift_half_away(v);
        end
        if (ok && !(sx >= 0 && sx < wl && sy >= 0 && sy < hl))
            ok = 1'b0;
        r.src_x      = ok ? sx[iwsa_pkg::FIELD_BITS-1:0] : '0;
        r.src_y      = ok ? sy[iwsa_pkg::FIELD_BITS-1:0] : '0;
        r.inside_res = ok;
        return r;
    endfunction

    always @(posedge i_clk) begin
        iwsa_pkg::t_out exp_r;
        if (!i_rst_n) begin
            row0_a_b    <= 64'd1 << FRAC;
            row0c_row1a <= '0;
            row1_b_c    <= 64'd1 << FRAC;
            row2_a_b    <= '0;
            row2_c      <= 32'd1 << FRAC;
            persp       <= 1'b1;
            width       <= 13'd4096;
            height      <= 13'd4096;
            src_q.delete();
            o_pending   <= 0;
            o_failures  <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                src_q = {src_q, predict_source(i_in)};
            if (i_out_valid && i_out_ready) begin
                if (src_q.size() == 0) begin
                    $error("result transfer with no expectation: %h", i_out);
                    o_failures <= o_failures + 1;
                end else begin
                    exp_r = src_q.pop_front();
                    if (i_out.src_x !== exp_r.src_x || i_out.src_y !== exp_r.src_y ||
                        i_out.inside_res !== exp_r.inside_res)
                        o_failures <= o_failures + 1;
                    if (i_out.src_x !== exp_r.src_x)
                        $error("src_x expected %0d actual %0d", exp_r.src_x, i_out.src_x);
                    if (i_out.src_y !== exp_r.src_y)
                        $error("src_y expected %0d actual %0d", exp_r.src_y, i_out.src_y);
                    if (i_out.inside_res !== exp_r.inside_res)
                        $error("inside_res expected %0d actual %0d",
                               exp_r.inside_res, i_out.inside_res);
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    iwsa_pkg::REG_ROW0_A_B:    row0_a_b    <= pwdata;
                    iwsa_pkg::REG_ROW0C_ROW1A: row0c_row1a <= pwdata;
                    iwsa_pkg::REG_ROW1_B_C:    row1_b_c    <= pwdata;
                    iwsa_pkg::REG_ROW2_A_B:    row2_a_b    <= pwdata;
                    iwsa_pkg::REG_ROW2_C:      row2_c      <= pwdata[31:0];
                    iwsa_pkg::REG_PERSP:       persp       <= pwdata[0];
                    iwsa_pkg::REG_SRC_WIDTH:   width       <= pwdata[iwsa_pkg::SIZE_BITS-1:0];
                    iwsa_pkg::REG_SRC_HEIGHT:  height      <= pwdata[iwsa_pkg::SIZE_BITS-1:0];
                    default: ;
                endcase
            end
            o_pending <= src_q.size();
        end
    end

endmodule

>>> tb/inverse_warp_source_address_unit_test.sv
// testbench top: drives stimulus and configuration, gives the verdict
module inverse_warp_source_address_unit_test;

    localparam int ONE      = 1 << iwsa_pkg::COEF_FRAC_BITS_DEF;
    localparam int IDLE_PCT = 27;
    localparam int STALL_LIMIT = 5000;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    iwsa_pkg::t_in                   i_in;
    logic                            o_out_valid;
    logic                            i_out_ready;
    iwsa_pkg::t_out                  o_out;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [iwsa_pkg::ADDR_BITS-1:0]  paddr;
    logic [iwsa_pkg::DATA_BITS-1:0]  pwdata;
    logic [iwsa_pkg::DATA_BITS-1:0]  prdata;
    logic                            pready;

    int pending;
    int failures;
    int stall_cnt;
    int sent;
    int phases;
    bit calm;

    logic [31:0]                    m [9];
    logic                           cfg_persp;
    logic [iwsa_pkg::SIZE_BITS-1:0] cfg_w;
    logic [iwsa_pkg::SIZE_BITS-1:0] cfg_h;

    inverse_warp_source_address_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    source_address_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in(i_in),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out(o_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_pending(pending), .o_failures(failures)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic drain();
        while (pending != 0 || i_in_valid)
            @(posedge i_clk);
        repeat (iwsa_pkg::COORD_BITS_DEF + 20) @(posedge i_clk);
    endtask

    task automatic end_burst();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        drain();
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= iwsa_pkg::ADDR_BITS'({idx, 3'b000});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // registers change only with the pipeline empty
    task automatic load_cfg();
        end_burst();
        write_reg(iwsa_pkg::REG_ROW0_A_B,    {m[1], m[0]});
        write_reg(iwsa_pkg::REG_ROW0C_ROW1A, {m[3], m[2]});
        write_reg(iwsa_pkg::REG_ROW1_B_C,    {m[5], m[4]});
        write_reg(iwsa_pkg::REG_ROW2_A_B,    {m[7], m[6]});
        write_reg(iwsa_pkg::REG_ROW2_C,      {$urandom(), m[8]});
        write_reg(iwsa_pkg::REG_PERSP,       {$urandom(), 31'($urandom()), cfg_persp});
        write_reg(iwsa_pkg::REG_SRC_WIDTH,   {$urandom(), 19'($urandom()), cfg_w});
        write_reg(iwsa_pkg::REG_SRC_HEIGHT,  {$urandom(), 19'($urandom()), cfg_h});
    endtask

    task automatic set_identity(bit persp);
        for (int i = 0; i < 9; i++)
            m[i] = 32'd0;
        m[0] = ONE;
        m[4] = ONE;
        m[8] = ONE;
        cfg_persp = persp;
        cfg_w = 13'd4096;
        cfg_h = 13'd4096;
    endtask

    task automatic send(logic [11:0] x, logic [11:0] y);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PCT);
        end
        i_in.out_x <= x;
        i_in.out_y <= y;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    function automatic logic [31:0] jitter(int span);
        return 32'(int'($urandom_range(2 * span)) - span);
    endfunction

    task automatic pick_cfg(int kind);
        set_identity(kind == 1);
        case (kind)
            0, 1: begin
                m[0] = ONE + jitter(ONE / 4);
                m[1] = jitter(ONE / 4);
                m[2] = jitter(ONE * 300);
                m[3] = jitter(ONE / 4);
                m[4] = ONE + jitter(ONE / 4);
                m[5] = jitter(ONE * 300);
                if (kind == 1) begin
                    m[6] = jitter(256);
                    m[7] = jitter(256);
                    m[8] = ONE + jitter(ONE / 8);
                end
            end
            default: begin
                for (int i = 0; i < 9; i++)
                    m[i] = $urandom();
                cfg_persp = 1'($urandom_range(1));
            end
        endcase
        case ($urandom_range(9))
            0:       cfg_w = 13'($urandom_range(4097, 8191));
            1:       cfg_w = 13'd0;
            default: cfg_w = 13'($urandom_range(1, 4096));
        endcase
        case ($urandom_range(9))
            0:       cfg_h = 13'($urandom_range(4097, 8191));
            1:       cfg_h = 13'd0;
            default: cfg_h = 13'($urandom_range(1, 4096));
        endcase
    endtask

    initial begin
        int kind;
        int n;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        calm       = 1'b0;
        sent       = 0;
        phases     = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: identity in perspective mode
        send(12'd0, 12'd0);
        send(12'd4095, 12'd4095);
        send(12'd1234, 12'd2961);
        end_burst();

        // affine identity, then negative half and quarter offsets
        set_identity(1'b0);
        load_cfg();
        send(12'd4095, 12'd0);
        send(12'd0, 12'd4095);
        m[2] = -(ONE / 2);
        load_cfg();
        send(12'd0, 12'd5);
        send(12'd1, 12'd5);
        m[2] = -(ONE / 4);
        load_cfg();
        send(12'd0, 12'd5);
        end_burst();

        // perspective halves with W = 2.0 and negative half
        set_identity(1'b1);
        m[8] = 2 * ONE;
        load_cfg();
        send(12'd1, 12'd3);
        m[2] = -ONE;
        load_cfg();
        send(12'd0, 12'd1);
        end_burst();

        // zero divisor
        set_identity(1'b1);
        m[8] = 32'd0;
        load_cfg();
        send(12'd0, 12'd0);
        send(12'd7, 12'd9);
        end_burst();

        // coefficient extremes
        for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < 9; i++)
                m[i] = k ? 32'h7FFF_FFFF : 32'h8000_0000;
            cfg_persp = 1'(k);
            load_cfg();
            send(12'd4095, 12'd4095);
            send(12'd0, 12'd0);
            end_burst();
        end

        // size extremes: zero, one, oversized
        set_identity(1'b0);
        cfg_w = 13'd0;
        load_cfg();
        send(12'd0, 12'd0);
        cfg_w = 13'd1;
        cfg_h = 13'd1;
        load_cfg();
        send(12'd0, 12'd0);
        send(12'd1, 12'd0);
        cfg_w = 13'd8191;
        cfg_h = 13'd8191;
        load_cfg();
        send(12'd4095, 12'd4095);
        end_burst();

        for (int p = 0; p < 10; p++) begin
            kind = (p % 5 == 4) ? 2 : (p % 2);
            pick_cfg(kind);
            load_cfg();
            phases++;
            calm = (p == 3);
            n = 70;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(1))
                    send(12'($urandom()), 12'($urandom()));
                else
                    send(12'($urandom_range(cfg_w > 13'd4096 ? 4095 : cfg_w)),
                         12'($urandom_range(cfg_h > 13'd4096 ? 4095 : cfg_h)));
                if (i == n / 2 && p == 5) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending != 0)
                        @(posedge i_clk);
                end
            end
            end_burst();
            calm = 1'b0;
        end

        $display("covered %0d coordinate transfers over directed cases and %0d random settings",
                 sent, phases);
        $display("affine and perspective modes, zero divisor, half rounding, size extremes");
        if (failures == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
